FILE: rtl/sps_pkg.sv
package sps_pkg;

    // Fixed sizes of the mapping
    localparam int MAX_DISKS         = 16;
    localparam int MAX_REQUEST_BYTES = 65536;
    localparam int SECTOR_SHIFT      = 10;
    localparam int MIN_LOG2_STRIPE   = 12;

    // Field widths
    localparam int ADDR_W     = 32;
    localparam int LEN_W      = 17;
    localparam int LOG2_W     = 5;
    localparam int DEVCNT_W   = 5;
    localparam int SECTOR_W   = 22;
    localparam int BUF_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Derived widths
    localparam int DISK_W      = $clog2(MAX_DISKS);
    localparam int DIV_W       = $clog2(MAX_DISKS + 1);
    localparam int QUOT_W      = ADDR_W - MIN_LOG2_STRIPE;
    localparam int DIV_STEP_W  = $clog2(QUOT_W);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOG2_STRIPE   = 2'd0,
        REG_DEVICE_COUNT  = 2'd1,
        REG_SECTION_START = 2'd2
    } cfg_reg_t;

    // Effective configuration seen by the datapath
    typedef struct packed {
        logic [LOG2_W-1:0] log2;
        logic [DIV_W-1:0]  disks;
        logic [ADDR_W-1:0] section;
    } cfg_t;

    // Classified request handed from front to back
    typedef struct packed {
        logic [ADDR_W-1:0] offset;
        logic [LEN_W-1:0]  length;
        logic [QUOT_W-1:0] quot;
        logic [DISK_W-1:0] remd;
    } desc_t;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_DIV,
        FS_PUSH
    } front_state_t;

    // Clamp the stripe size to its minimum
    function automatic logic [LOG2_W-1:0] eff_log2(input logic [LOG2_W-1:0] raw);
        logic [LOG2_W-1:0] res;
        res = raw;
        if (int'(raw) < MIN_LOG2_STRIPE)
        begin
            res = LOG2_W'(MIN_LOG2_STRIPE);
        end
        return res;
    endfunction

    // Map a zero disk count to one and cap at the maximum
    function automatic logic [DIV_W-1:0] eff_disks(input logic [DEVCNT_W-1:0] raw);
        logic [DIV_W-1:0] res;
        res = DIV_W'(raw);
        if (raw == '0)
        begin
            res = DIV_W'(1);
        end
        else if (int'(raw) > MAX_DISKS)
        begin
            res = DIV_W'(MAX_DISKS);
        end
        return res;
    endfunction

    // Cut an overlong request
    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] raw);
        logic [LEN_W-1:0] res;
        res = raw;
        if (int'(raw) > MAX_REQUEST_BYTES)
        begin
            res = LEN_W'(MAX_REQUEST_BYTES);
        end
        return res;
    endfunction

endpackage

FILE: rtl/sps_front.sv
module sps_front
    import sps_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              push,
    output logic              full,
    input  logic [ADDR_W-1:0] request_offset,
    input  logic [LEN_W-1:0]  request_length,
    output logic              q_wr,
    input  logic              q_full,
    output desc_t             q_data
);

    front_state_t      state_reg, state_next;
    logic [ADDR_W-1:0] off_reg, off_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [QUOT_W-1:0] dvd_reg, dvd_next;
    logic [DISK_W-1:0] part_reg, part_next;
    logic [DIV_STEP_W-1:0] step_reg, step_next;

    logic [LEN_W-1:0]  len_clamped;
    logic [DISK_W:0]   shifted;
    logic [DISK_W:0]   divisor;
    logic [DISK_W:0]   diff;
    logic              ge;

    assign len_clamped = clamp_len(request_length);

    // One restoring division step: stripe number by disk count
    assign shifted = {part_reg, dvd_reg[QUOT_W-1]};
    assign divisor = (DISK_W+1)'(cfg.disks);
    assign ge      = (shifted >= divisor);
    assign diff    = shifted - divisor;

    assign full   = (state_reg != FS_IDLE);
    assign q_data = '{offset: off_reg, length: len_reg, quot: dvd_reg, remd: part_reg};

    // Hold the state and the division registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FS_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        off_reg  <= off_next;
        len_reg  <= len_next;
        dvd_reg  <= dvd_next;
        part_reg <= part_next;
    end

    // Accept, divide, then push the classified request
    always_comb
    begin
        state_next = state_reg;
        off_next   = off_reg;
        len_next   = len_reg;
        dvd_next   = dvd_reg;
        part_next  = part_reg;
        step_next  = step_reg;
        q_wr       = 1'b0;
        unique case (state_reg)
            FS_IDLE:
            begin
                // Drop zero-length transactions here
                if (push && (len_clamped != '0))
                begin
                    off_next   = request_offset;
                    len_next   = len_clamped;
                    dvd_next   = QUOT_W'(request_offset >> cfg.log2);
                    part_next  = '0;
                    step_next  = '0;
                    state_next = FS_DIV;
                end
            end
            FS_DIV:
            begin
                dvd_next  = {dvd_reg[QUOT_W-2:0], ge};
                part_next = ge ? diff[DISK_W-1:0] : shifted[DISK_W-1:0];
                step_next = step_reg + 1'b1;
                if (step_reg == DIV_STEP_W'(QUOT_W - 1))
                begin
                    state_next = FS_PUSH;
                end
            end
            FS_PUSH:
            begin
                if (!q_full)
                begin
                    q_wr       = 1'b1;
                    state_next = FS_IDLE;
                end
            end
            default:
            begin
                state_next = FS_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/sps_queue.sv
module sps_queue
    import sps_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_en,
    input  desc_t wr_data,
    output logic  full,
    input  logic  rd_en,
    output desc_t rd_data,
    output logic  empty
);

    desc_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_wr;
    logic              do_rd;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    // Advance the pointers and the fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming descriptor
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: rtl/sps_back.sv
module sps_back
    import sps_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  logic                q_empty,
    input  desc_t               q_data,
    output logic                q_rd,
    output logic                empty,
    input  logic                pop,
    output logic [DISK_W-1:0]   disk_index,
    output logic [ADDR_W-1:0]   physical_offset,
    output logic [SECTOR_W-1:0] sector_number,
    output logic [LEN_W-1:0]    chunk_bytes,
    output logic [BUF_W-1:0]    buffer_position,
    output logic                last_chunk
);

    // Chunk walker state
    logic              busy_reg, busy_next;
    logic [ADDR_W-1:0] off_reg, off_next;
    logic [LEN_W-1:0]  rem_reg, rem_next;
    logic [LEN_W-1:0]  buf_reg, buf_next;
    logic [QUOT_W-1:0] quot_reg, quot_next;
    logic [DISK_W-1:0] remd_reg, remd_next;

    // Output register
    logic                out_valid_reg, out_valid_next;
    logic [DISK_W-1:0]   disk_reg, disk_next;
    logic [ADDR_W-1:0]   phys_reg, phys_next;
    logic [LEN_W-1:0]    cnt_reg, cnt_next;
    logic [BUF_W-1:0]    bpos_reg, bpos_next;
    logic                last_reg, last_next;

    logic [ADDR_W-1:0] size;
    logic [ADDR_W-1:0] low;
    logic [ADDR_W-1:0] gap;
    logic              is_last;
    logic [LEN_W-1:0]  cnt;
    logic [ADDR_W-1:0] phys;
    logic [ADDR_W:0]   off_sum;
    logic [DIV_W-1:0]  remd_inc;
    logic              emit;

    function automatic logic [SECTOR_W-1:0] sector_from(input logic [ADDR_W-1:0] p);
        logic [ADDR_W-1:0] s;
        s = p >> SECTOR_SHIFT;
        return s[SECTOR_W-1:0];
    endfunction

    // Chunk size: up to the next stripe boundary or the rest of the request
    assign size    = ADDR_W'(1) << cfg.log2;
    assign low     = off_reg & (size - 1'b1);
    assign gap     = size - low;
    assign is_last = (gap >= ADDR_W'(rem_reg));
    assign cnt     = is_last ? rem_reg : gap[LEN_W-1:0];
    assign phys    = cfg.section + (ADDR_W'(quot_reg) << cfg.log2) + low;
    assign off_sum = {1'b0, off_reg} + (ADDR_W+1)'(cnt);
    assign remd_inc = DIV_W'(remd_reg) + 1'b1;

    assign emit = busy_reg && (!out_valid_reg || pop);
    assign q_rd = !busy_reg && !q_empty;

    assign empty           = !out_valid_reg;
    assign disk_index      = disk_reg;
    assign physical_offset = phys_reg;
    assign sector_number   = sector_from(phys_reg);
    assign chunk_bytes     = cnt_reg;
    assign buffer_position = bpos_reg;
    assign last_chunk      = last_reg;

    // Load a descriptor, then emit one chunk per cycle the output allows
    always_comb
    begin
        busy_next      = busy_reg;
        off_next       = off_reg;
        rem_next       = rem_reg;
        buf_next       = buf_reg;
        quot_next      = quot_reg;
        remd_next      = remd_reg;
        out_valid_next = out_valid_reg;
        disk_next      = disk_reg;
        phys_next      = phys_reg;
        cnt_next       = cnt_reg;
        bpos_next      = bpos_reg;
        last_next      = last_reg;

        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end

        if (q_rd)
        begin
            busy_next = 1'b1;
            off_next  = q_data.offset;
            rem_next  = q_data.length;
            buf_next  = '0;
            quot_next = q_data.quot;
            remd_next = q_data.remd;
        end
        else if (emit)
        begin
            out_valid_next = 1'b1;
            disk_next      = remd_reg;
            phys_next      = phys;
            cnt_next       = cnt;
            bpos_next      = buf_reg[BUF_W-1:0];
            last_next      = is_last;

            off_next = off_sum[ADDR_W-1:0];
            rem_next = rem_reg - cnt;
            buf_next = buf_reg + cnt;
            if (is_last)
            begin
                busy_next = 1'b0;
            end
            // Past the top of the address space: restart at stripe zero
            if (off_sum[ADDR_W])
            begin
                quot_next = '0;
                remd_next = '0;
            end
            else if (remd_inc == cfg.disks)
            begin
                quot_next = quot_reg + 1'b1;
                remd_next = '0;
            end
            else
            begin
                remd_next = remd_inc[DISK_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        off_reg  <= off_next;
        rem_reg  <= rem_next;
        buf_reg  <= buf_next;
        quot_reg <= quot_next;
        remd_reg <= remd_next;
        disk_reg <= disk_next;
        phys_reg <= phys_next;
        cnt_reg  <= cnt_next;
        bpos_reg <= bpos_next;
        last_reg <= last_next;
    end

endmodule

FILE: rtl/stripe_request_splitter_core.sv
// Channel   Direction  Handshake             Payload
// request   in         push / full           request_offset, request_length
// chunk     out        empty / pop           disk_index, physical_offset, sector_number,
//                                            chunk_bytes, buffer_position, last_chunk
// config    in         cfg_write             cfg_index, cfg_data
//
// The front takes a new request only once it has pushed the last one: a 20-step
// shift-subtract divider splits the start stripe into row and disk, then a push
// state writes the queue. The back loads a descriptor from a two-entry queue, then
// emits one chunk per cycle while the output allows, stepping row and disk by increment.
// Reset (rst_n, asynchronous) empties both parts and restores the registers.
// A full queue stalls the front; a held chunk (pop low) stalls the back.
module stripe_request_splitter_core
    import sps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  push,
    output logic                  full,
    input  logic [ADDR_W-1:0]     request_offset,
    input  logic [LEN_W-1:0]      request_length,
    output logic                  empty,
    input  logic                  pop,
    output logic [DISK_W-1:0]     disk_index,
    output logic [ADDR_W-1:0]     physical_offset,
    output logic [SECTOR_W-1:0]   sector_number,
    output logic [LEN_W-1:0]      chunk_bytes,
    output logic [BUF_W-1:0]      buffer_position,
    output logic                  last_chunk
);

    logic [LOG2_W-1:0]   log2_reg, log2_next;
    logic [DEVCNT_W-1:0] devcnt_reg, devcnt_next;
    logic [ADDR_W-1:0]   section_reg, section_next;
    cfg_t                cfg;

    logic  q_wr;
    logic  q_full;
    desc_t q_wdata;
    logic  q_rd;
    logic  q_empty;
    desc_t q_rdata;

    // Decode configuration writes; drop unknown indexes
    always_comb
    begin
        log2_next    = log2_reg;
        devcnt_next  = devcnt_reg;
        section_next = section_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_LOG2_STRIPE:   log2_next    = cfg_data[LOG2_W-1:0];
                REG_DEVICE_COUNT:  devcnt_next  = cfg_data[DEVCNT_W-1:0];
                REG_SECTION_START: section_next = cfg_data[ADDR_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log2_reg    <= LOG2_W'(16);
            devcnt_reg  <= DEVCNT_W'(1);
            section_reg <= '0;
        end
        else
        begin
            log2_reg    <= log2_next;
            devcnt_reg  <= devcnt_next;
            section_reg <= section_next;
        end
    end

    // Clamp the registers into their working range
    assign cfg = '{log2: eff_log2(log2_reg), disks: eff_disks(devcnt_reg), section: section_reg};

    sps_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .push           (push),
        .full           (full),
        .request_offset (request_offset),
        .request_length (request_length),
        .q_wr           (q_wr),
        .q_full         (q_full),
        .q_data         (q_wdata)
    );

    sps_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_data (q_wdata),
        .full    (q_full),
        .rd_en   (q_rd),
        .rd_data (q_rdata),
        .empty   (q_empty)
    );

    sps_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .q_empty         (q_empty),
        .q_data          (q_rdata),
        .q_rd            (q_rd),
        .empty           (empty),
        .pop             (pop),
        .disk_index      (disk_index),
        .physical_offset (physical_offset),
        .sector_number   (sector_number),
        .chunk_bytes     (chunk_bytes),
        .buffer_position (buffer_position),
        .last_chunk      (last_chunk)
    );

endmodule
